[rtl/core/bmg_pkg.sv]
// bmg_pkg: shared types, constants and the cordic arctangent table for the
// bearing measurement gate. No dependencies.
package bmg_pkg;

  // default values for the top-level parameters
  localparam int POS_WIDTH_DEF    = 16;
  localparam int ANGLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // configuration register
  localparam int CFG_W          = 15;
  localparam int MIN_DIST_RESET = 192;
  localparam int LAST_Y_RESET   = -2 * MIN_DIST_RESET;

  // result fields
  localparam int DIST_W     = 16;
  localparam int MODE_W     = 2;
  localparam int OUT_BITS   = 1 + MODE_W + DIST_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_FLAGS   = 4;

  // cordic datapath
  localparam int CORDIC_W   = 33;              // q1.30 plus headroom and sign
  localparam int SC_W       = CORDIC_W - 6;    // q1.24 sin / cos
  localparam int ATAN_IDX_W = 5;
  localparam int ANG_W      = 32;              // internal angle, 2^32 per turn
  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [CORDIC_W-1:0] SC_ROUND = 33'sd32;
  localparam int DIST_SHIFT = 24;

  typedef enum logic [MODE_W-1:0] {
    GATE_IDLE         = 2'd0,
    GATE_WAIT_DETECT  = 2'd1,
    GATE_WAIT_RELEASE = 2'd2,
    GATE_DONE         = 2'd3
  } gate_mode_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ROT,
    SEQ_FIN,
    SEQ_MUL_C,
    SEQ_MUL_S,
    SEQ_DIST,
    SEQ_EMIT
  } seq_state_t;

  typedef struct packed {
    logic load;      // latch request, start rotation
    logic rot;       // one cordic micro-rotation
    logic fin;       // quadrant fix and round sin / cos
    logic mul_c;     // acc = dy * cos
    logic mul_s;     // acc -= dx * sin
    logic dist_sat;  // abs, round, saturate
    logic emit;      // gate update and result register load
    logic cfg_we;    // threshold write
  } bmg_cmd_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [ANG_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/bmg_ctrl.sv]
// bmg_ctrl: sequencer for one request: cordic rotations, multiply and
// distance steps, result handshake. Depends on bmg_pkg.
module bmg_ctrl #(
  parameter int CORDIC_STEPS = bmg_pkg::CORDIC_STEPS_DEF,
  parameter int SW           = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  output bmg_pkg::bmg_cmd_t cmd,
  output logic [SW-1:0]    step_idx
);

  bmg_pkg::seq_state_t state_r, state_nxt;
  logic [SW-1:0]       idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmg_pkg::SEQ_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_tready = 1'b0;
    cmd.cfg_we = cfg_valid;
    case (state_r)
      bmg_pkg::SEQ_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = bmg_pkg::SEQ_ROT;
        end
      end
      bmg_pkg::SEQ_ROT: begin
        cmd.rot = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == SW'(CORDIC_STEPS - 1)) begin
          state_nxt = bmg_pkg::SEQ_FIN;
        end
      end
      bmg_pkg::SEQ_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = bmg_pkg::SEQ_MUL_C;
      end
      bmg_pkg::SEQ_MUL_C: begin
        cmd.mul_c = 1'b1;
        state_nxt = bmg_pkg::SEQ_MUL_S;
      end
      bmg_pkg::SEQ_MUL_S: begin
        cmd.mul_s = 1'b1;
        state_nxt = bmg_pkg::SEQ_DIST;
      end
      bmg_pkg::SEQ_DIST: begin
        cmd.dist_sat = 1'b1;
        state_nxt    = bmg_pkg::SEQ_EMIT;
      end
      bmg_pkg::SEQ_EMIT: begin
        // hold here while the previous result is still unclaimed
        if (!out_valid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = bmg_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = bmg_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign cfg_ready  = 1'b1;
  assign step_idx   = idx_r;

endmodule

[rtl/core/bmg_dp.sv]
// bmg_dp: datapath with cordic sin / cos, shared multiplier, ray distance,
// gate mode state, stored ray and result register. Depends on bmg_pkg.
module bmg_dp #(
  parameter int POS_WIDTH    = bmg_pkg::POS_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = bmg_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = bmg_pkg::CORDIC_STEPS_DEF,
  parameter int SW           = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bmg_pkg::bmg_cmd_t               cmd,
  input  logic [SW-1:0]                   step_idx,
  input  logic [bmg_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            found_position,
  input  logic                            signal_stable,
  input  logic                            found_bearing,
  input  logic                            bearing_given_up,
  input  logic [ANGLE_WIDTH-1:0]          bearing_angle,
  input  logic signed [POS_WIDTH-1:0]     pos_x,
  input  logic signed [POS_WIDTH-1:0]     pos_y,
  output logic                            need_bearing,
  output logic [bmg_pkg::MODE_W-1:0]      gate_mode,
  output logic [bmg_pkg::DIST_W-1:0]      ray_distance
);

  // stored position wide enough for the reset value of last_y
  localparam int LW   = (POS_WIDTH > 12) ? POS_WIDTH : 12;
  localparam int CW   = bmg_pkg::CORDIC_W;
  localparam int SCW  = bmg_pkg::SC_W;
  localparam int PRW  = LW + 1 + SCW;
  localparam int ACW  = PRW + 1;
  localparam int QW   = ACW + 1 - bmg_pkg::DIST_SHIFT;
  localparam int DW   = bmg_pkg::DIST_W;

  // configuration and gate state
  logic [bmg_pkg::CFG_W-1:0] thresh_r;
  bmg_pkg::gate_mode_t       mode_r, mode_nxt;
  logic                      need_r, need_nxt;
  logic signed [LW-1:0]      last_x_r, last_y_r;
  logic [ANGLE_WIDTH-1:0]    last_ang_r;
  logic                      store;

  // latched request
  logic                      fp_r, ss_r, fb_r, gu_r;
  logic [ANGLE_WIDTH-1:0]    ang_r;
  logic signed [POS_WIDTH-1:0] px_r, py_r;
  logic signed [LW:0]        dx_r, dy_r;

  // cordic
  logic signed [CW-1:0]      x_r, y_r, z_r;
  logic                      flip_r;
  logic [bmg_pkg::ANG_W-1:0] z32;
  logic signed [CW-1:0]      xs, ys, atan_v, cx, sy, cr, sr;
  logic signed [SCW-1:0]     c_r, s_r;

  // product and distance
  logic signed [LW:0]        opa;
  logic signed [SCW-1:0]     opb;
  logic signed [PRW-1:0]     prod;
  logic signed [ACW-1:0]     acc_r;
  logic [ACW-1:0]            mag;
  logic [ACW:0]              rnd;
  logic [QW-1:0]             q;
  logic [DW-1:0]             dist_r;

  // result register
  logic                      out_need_r;
  logic [bmg_pkg::MODE_W-1:0] out_mode_r;
  logic [DW-1:0]             out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r   <= bmg_pkg::CFG_W'(bmg_pkg::MIN_DIST_RESET);
      mode_r     <= bmg_pkg::GATE_IDLE;
      need_r     <= 1'b0;
      last_x_r   <= '0;
      last_y_r   <= LW'(bmg_pkg::LAST_Y_RESET);
      last_ang_r <= '0;
    end else begin
      if (cmd.cfg_we) begin
        thresh_r <= cfg_data;
      end
      if (cmd.emit) begin
        mode_r <= mode_nxt;
        need_r <= need_nxt;
        if (store) begin
          last_x_r   <= LW'(px_r);
          last_y_r   <= LW'(py_r);
          last_ang_r <= ang_r;
        end
      end
    end
  end

  // angle widened to 2^32 per turn; angles in the left half plane are turned
  // by half a turn and the results negated afterwards
  assign z32    = {last_ang_r, {(bmg_pkg::ANG_W - ANGLE_WIDTH){1'b0}}};
  assign xs     = x_r >>> step_idx;
  assign ys     = y_r >>> step_idx;
  assign atan_v = CW'(bmg_pkg::atan_turn(bmg_pkg::ATAN_IDX_W'(step_idx)));
  assign cx     = flip_r ? -x_r : x_r;
  assign sy     = flip_r ? -y_r : y_r;
  assign cr     = cx + bmg_pkg::SC_ROUND;
  assign sr     = sy + bmg_pkg::SC_ROUND;

  // one multiplier shared by the two products
  assign opa  = cmd.mul_c ? dy_r : dx_r;
  assign opb  = cmd.mul_c ? c_r : s_r;
  assign prod = PRW'(opa) * PRW'(opb);

  assign mag = acc_r[ACW-1] ? ACW'(-acc_r) : ACW'(acc_r);
  assign rnd = {1'b0, mag} + (ACW + 1)'(1 << (bmg_pkg::DIST_SHIFT - 1));
  assign q   = rnd[ACW:bmg_pkg::DIST_SHIFT];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fp_r   <= found_position;
      ss_r   <= signal_stable;
      fb_r   <= found_bearing;
      gu_r   <= bearing_given_up;
      ang_r  <= bearing_angle;
      px_r   <= pos_x;
      py_r   <= pos_y;
      dx_r   <= (LW + 1)'(pos_x) - (LW + 1)'(last_x_r);
      dy_r   <= (LW + 1)'(pos_y) - (LW + 1)'(last_y_r);
      flip_r <= z32[bmg_pkg::ANG_W-1] ^ z32[bmg_pkg::ANG_W-2];
      x_r    <= bmg_pkg::GAIN_Q30;
      y_r    <= '0;
      z_r    <= CW'($signed({z32[bmg_pkg::ANG_W-1] ^ (z32[bmg_pkg::ANG_W-1] ^
                 z32[bmg_pkg::ANG_W-2]), z32[bmg_pkg::ANG_W-2:0]}));
    end
    if (cmd.rot) begin
      if (!z_r[CW-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_v;
      end
    end
    if (cmd.fin) begin
      c_r <= cr[CW-1:6];
      s_r <= sr[CW-1:6];
    end
    if (cmd.mul_c) begin
      acc_r <= ACW'(prod);
    end
    if (cmd.mul_s) begin
      acc_r <= acc_r - ACW'(prod);
    end
    if (cmd.dist_sat) begin
      dist_r <= (|q[QW-1:DW]) ? {DW{1'b1}} : q[DW-1:0];
    end
    if (cmd.emit) begin
      out_need_r <= need_nxt;
      out_mode_r <= mode_nxt;
      out_dist_r <= dist_r;
    end
  end

  // gate update; found_position overrides everything and done is absorbing
  always_comb begin
    mode_nxt = fp_r ? bmg_pkg::GATE_DONE : mode_r;
    need_nxt = fp_r ? 1'b0 : need_r;
    store    = 1'b0;
    case (mode_nxt)
      bmg_pkg::GATE_IDLE: begin
        if (ss_r && (dist_r >= DW'(thresh_r))) begin
          mode_nxt = bmg_pkg::GATE_WAIT_DETECT;
          need_nxt = 1'b1;
        end
      end
      bmg_pkg::GATE_WAIT_DETECT: begin
        if (fb_r || gu_r) begin
          mode_nxt = bmg_pkg::GATE_WAIT_RELEASE;
          need_nxt = 1'b0;
          store    = fb_r;
        end
      end
      bmg_pkg::GATE_WAIT_RELEASE: begin
        if (!fb_r && !gu_r) begin
          mode_nxt = bmg_pkg::GATE_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  assign need_bearing = out_need_r;
  assign gate_mode    = out_mode_r;
  assign ray_distance = out_dist_r;

endmodule

[rtl/core/bearing_measurement_gate_top.sv]
// bearing_measurement_gate_top: stream ports, field packing, sequencer and
// datapath. Depends on bmg_pkg, bmg_ctrl, bmg_dp.
//
//   channel  ports                          carries
//   in_      in_tvalid/in_tready/in_tdata   one tick: flags, bearing, position
//   out_     out_tvalid/out_tready/out_tdata request flag, gate mode, distance
//   cfg_     cfg_valid/cfg_ready/cfg_data   min_ray_distance threshold
//
// each request's span from accept to the next accept is set by the
// one-step-per-cycle cordic rotation and the single shared multiplier. the
// result register lets a new request start while the last result waits; a
// request finishing before that result is taken holds in its final step.
// rst_n is synchronous; cfg_ready is always high.
module bearing_measurement_gate_top #(
  parameter int POS_WIDTH    = bmg_pkg::POS_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = bmg_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = bmg_pkg::CORDIC_STEPS_DEF,
  parameter int IN_DATA_W    = ((bmg_pkg::IN_FLAGS + ANGLE_WIDTH + 2 * POS_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // found_position, signal_stable, found_bearing, bearing_given_up,
  // bearing_angle, pos_x, pos_y
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_DATA_W-1:0]             in_tdata,
  // need_bearing, gate_mode, ray_distance
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bmg_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmg_pkg::CFG_W-1:0]        cfg_data
);

  localparam int SW  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int AB  = bmg_pkg::IN_FLAGS;
  localparam int XB  = AB + ANGLE_WIDTH;
  localparam int YB  = XB + POS_WIDTH;

  bmg_pkg::bmg_cmd_t               cmd;
  logic [SW-1:0]                   step_idx;
  logic                            need_bearing;
  logic [bmg_pkg::MODE_W-1:0]      gate_mode;
  logic [bmg_pkg::DIST_W-1:0]      ray_distance;

  bmg_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .SW           (SW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd),
    .step_idx   (step_idx)
  );

  bmg_dp #(
    .POS_WIDTH    (POS_WIDTH),
    .ANGLE_WIDTH  (ANGLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS),
    .SW           (SW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .step_idx         (step_idx),
    .cfg_data         (cfg_data),
    .found_position   (in_tdata[0]),
    .signal_stable    (in_tdata[1]),
    .found_bearing    (in_tdata[2]),
    .bearing_given_up (in_tdata[3]),
    .bearing_angle    (in_tdata[XB-1:AB]),
    .pos_x            ($signed(in_tdata[YB-1:XB])),
    .pos_y            ($signed(in_tdata[YB+POS_WIDTH-1:YB])),
    .need_bearing     (need_bearing),
    .gate_mode        (gate_mode),
    .ray_distance     (ray_distance)
  );

  assign out_tdata = {{(bmg_pkg::OUT_DATA_W - bmg_pkg::OUT_BITS){1'b0}},
                      ray_distance, gate_mode, need_bearing};

endmodule
